@@ hw/rtl/dns_pkg.sv @@
`default_nettype none

package dns_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 16;
    localparam int ID_W        = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int DIST_W      = SQ_W + 1;
    localparam int ENTRY_W     = ID_W + 2 * COORD_WIDTH;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_NAV = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic load;
        logic add;
        logic set;
        logic rd_en;
        logic scan;
        logic scan_start;
        logic fallback;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       issue_more;
        logic       find_hit;
        logic       find_last;
        logic       pipe_busy;
    } t_status;

    function automatic t_coord to_coord(input logic signed [15:0] v);
        return t_coord'(v);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dns_ram.sv @@
`default_nettype none

module dns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/dns_datapath.sv @@
`default_nettype none

module dns_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dns_pkg::t_cmd             i_cmd,
    output dns_pkg::t_status               o_status,
    input  wire logic [1:0]                i_mode,
    input  wire logic [dns_pkg::ID_W-1:0]  i_object_id,
    input  wire logic signed [15:0]        i_pos_x,
    input  wire logic signed [15:0]        i_pos_y,
    input  wire logic [1:0]                i_direction,
    output logic      [dns_pkg::ID_W-1:0]  o_selection,
    output logic                           o_selection_valid,
    output logic                           o_add_dropped
);

    import dns_pkg::*;

    // latched request
    logic [1:0]      r_mode;
    logic [ID_W-1:0] r_id;
    t_coord          r_x;
    t_coord          r_y;
    logic [1:0]      r_dir;

    logic [CNT_W-1:0] r_count;
    logic [ID_W-1:0]  r_sel;
    logic             r_sel_valid;
    logic             r_dropped;
    logic [CNT_W-1:0] r_addr;

    logic [ID_W-1:0] r_cur_id;
    t_coord          r_cx;
    t_coord          r_cy;
    logic [ID_W-1:0] r_id0;

    // read stage
    logic             r_v1;
    logic             r_scan1;
    logic [CNT_W-1:0] r_idx1;
    logic [ENTRY_W-1:0] w_q;

    // difference stage
    logic                   r_v2;
    logic [COORD_WIDTH-1:0] r_ax;
    logic [COORD_WIDTH-1:0] r_ay;
    logic [ID_W-1:0]        r_id2;

    // square stage
    logic              r_v3;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [ID_W-1:0]   r_id3;

    logic              r_have_best;
    logic [DIST_W-1:0] r_best_dist;
    logic [ID_W-1:0]   r_best_id;

    logic              full;
    logic              wr_en;
    logic [ID_W-1:0]   q_id;
    t_coord            q_x;
    t_coord            q_y;
    logic              find_data;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] adx;
    logic signed [DIFF_W-1:0] ady;
    logic              in_dir;
    logic              cand;
    logic [DIST_W-1:0] sum_sq;
    logic [ID_W-1:0]   id0_now;

    assign full  = (r_count == CNT_W'(MAX_POINTS));
    assign wr_en = i_cmd.add && !full;

    dns_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_id, r_x, r_y}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_q)
    );

    assign q_id = w_q[ENTRY_W-1 -: ID_W];
    assign q_x  = $signed(w_q[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign q_y  = $signed(w_q[COORD_WIDTH-1:0]);

    assign find_data = r_v1 && !r_scan1;
    assign id0_now   = (r_idx1 == '0) ? q_id : r_id0;

    always_comb begin
        dx  = DIFF_W'(q_x) - DIFF_W'(r_cx);
        dy  = DIFF_W'(q_y) - DIFF_W'(r_cy);
        adx = dx[DIFF_W-1] ? -dx : dx;
        ady = dy[DIFF_W-1] ? -dy : dy;
        unique case (r_dir)
            DIR_UP:    in_dir = dy[DIFF_W-1];
            DIR_DOWN:  in_dir = !dy[DIFF_W-1] && (dy != '0);
            DIR_LEFT:  in_dir = dx[DIFF_W-1];
            DIR_RIGHT: in_dir = !dx[DIFF_W-1] && (dx != '0);
            default:   in_dir = 1'b0;
        endcase
        cand   = r_v1 && r_scan1 && in_dir && (q_id != r_cur_id);
        sum_sq = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    always_comb begin
        o_status.mode       = r_mode;
        o_status.count_zero = (r_count == '0);
        o_status.issue_more = (r_addr < r_count);
        o_status.find_hit   = find_data && r_sel_valid && (q_id == r_sel);
        o_status.find_last  = find_data && ((r_idx1 + CNT_W'(1)) == r_count);
        o_status.pipe_busy  = (r_v1 && r_scan1) || r_v2 || r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sel       <= '0;
            r_sel_valid <= 1'b0;
            r_dropped   <= 1'b0;
            r_addr      <= '0;
            r_v1        <= 1'b0;
            r_scan1     <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_v1    <= i_cmd.rd_en;
            r_scan1 <= i_cmd.scan;
            r_v2    <= cand;
            r_v3    <= r_v2;

            if (i_cmd.load || i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_addr <= r_addr + CNT_W'(1);
            end

            if (i_cmd.load) begin
                r_dropped <= 1'b0;
            end

            if (i_cmd.add) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    if (!r_sel_valid) begin
                        r_sel       <= r_id;
                        r_sel_valid <= 1'b1;
                    end
                end
            end

            if (i_cmd.set) begin
                r_sel       <= r_id;
                r_sel_valid <= 1'b1;
            end

            if (i_cmd.fallback) begin
                r_sel       <= id0_now;
                r_sel_valid <= 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_have_best <= 1'b0;
            end else if (r_v3 && (!r_have_best || sum_sq < r_best_dist)) begin
                r_have_best <= 1'b1;
            end

            if (i_cmd.commit && r_have_best) begin
                r_sel <= r_best_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_object_id;
            r_x    <= to_coord(i_pos_x);
            r_y    <= to_coord(i_pos_y);
            r_dir  <= i_direction;
        end
        r_idx1 <= r_addr;
        if (find_data && (r_idx1 == '0)) begin
            r_id0 <= q_id;
        end
        if (i_cmd.scan_start) begin
            r_cur_id <= q_id;
            r_cx     <= q_x;
            r_cy     <= q_y;
        end
        r_ax  <= COORD_WIDTH'(adx);
        r_ay  <= COORD_WIDTH'(ady);
        r_id2 <= q_id;
        r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_id3 <= r_id2;
        if (r_v3 && (!r_have_best || sum_sq < r_best_dist)) begin
            r_best_dist <= sum_sq;
            r_best_id   <= r_id3;
        end
    end

    assign o_selection       = r_sel;
    assign o_selection_valid = r_sel_valid;
    assign o_add_dropped     = r_dropped;

endmodule

`default_nettype wire

@@ hw/rtl/dns_ctrl.sv @@
`default_nettype none

module dns_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_out_free,
    output logic                  o_res_push,
    input  wire dns_pkg::t_status i_status,
    output dns_pkg::t_cmd         o_cmd
);

    import dns_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE) && i_rst_n;
        o_res_push = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.mode)
                    MODE_ADD: begin
                        o_cmd.add = 1'b1;
                        n_state   = S_DONE;
                    end
                    MODE_SET: begin
                        o_cmd.set = 1'b1;
                        n_state   = S_DONE;
                    end
                    MODE_NAV: begin
                        n_state = i_status.count_zero ? S_DONE : S_FIND;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FIND: begin
                o_cmd.rd_en = i_status.issue_more && !i_status.find_hit;
                priority if (i_status.find_hit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_status.find_last) begin
                    o_cmd.fallback = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = i_status.issue_more;
                o_cmd.scan  = 1'b1;
                if (!i_status.issue_more && !i_status.pipe_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                o_res_push = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/directional_nearest_select.sv @@
`default_nettype none

// Keeps a table of up to MAX_POINTS points (id, signed Q11.4 X and Y) and the
// id of the current selection. Each request on the slave stream gives exactly one
// response on the master stream. tuser selects the request kind: add a point,
// navigate in a direction, or set the selection. Add, set and unused kinds go
// straight from decode to done. A navigate over a table of N points reads the
// point memory once per cycle through its single read port, first to locate the
// current point and then to compare every entry; if it is not found, the first
// entry becomes the selection. One request is worked on at a time; a finished
// response waits in an output register while the next request is taken.

module directional_nearest_select (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // object_id[15:0], pos_x[31:16], pos_y[47:32], direction[49:48], zero pad
    input  wire logic [dns_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  wire logic [dns_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // selection[15:0]
    output logic      [dns_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // selection_valid[0], add_dropped[1]
    output logic      [dns_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    import dns_pkg::*;

    t_cmd            cmd;
    t_status         status;
    logic            out_free;
    logic            res_push;
    logic [ID_W-1:0] dp_sel;
    logic            dp_sel_valid;
    logic            dp_dropped;

    logic            r_out_valid;
    logic [ID_W-1:0] r_out_sel;
    logic            r_out_sel_valid;
    logic            r_out_dropped;

    assign out_free = !r_out_valid || m_axis_tready;

    dns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .o_res_push (res_push),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dns_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_mode            (s_axis_tuser[1:0]),
        .i_object_id       (s_axis_tdata[15:0]),
        .i_pos_x           ($signed(s_axis_tdata[31:16])),
        .i_pos_y           ($signed(s_axis_tdata[47:32])),
        .i_direction       (s_axis_tdata[49:48]),
        .o_selection       (dp_sel),
        .o_selection_valid (dp_sel_valid),
        .o_add_dropped     (dp_dropped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_push && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push && out_free) begin
            r_out_sel       <= dp_sel;
            r_out_sel_valid <= dp_sel_valid;
            r_out_dropped   <= dp_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sel;
    assign m_axis_tuser  = {r_out_dropped, r_out_sel_valid};

endmodule

`default_nettype wire

@@ hw/rtl/dns_checker.sv @@
`default_nettype none

module dns_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [dns_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input wire logic [dns_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [dns_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [dns_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    import dns_pkg::*;

    logic            in_acc;
    logic            out_acc;
    logic [1:0]      r_pending;
    logic            r_last_set;
    logic            r_last_add;
    logic [ID_W-1:0] r_last_id;
    logic            r_seen_valid;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_last_set   <= 1'b0;
            r_last_add   <= 1'b0;
            r_seen_valid <= 1'b0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
            if (in_acc) begin
                r_last_set <= (s_axis_tuser == MODE_SET);
                r_last_add <= (s_axis_tuser == MODE_ADD);
            end
            if (out_acc && m_axis_tuser[0]) begin
                r_seen_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last_id <= s_axis_tdata[15:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("response changed while stalled");

    a_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_pending == 2'd1) && r_last_set |->
            (m_axis_tdata[15:0] == r_last_id) && m_axis_tuser[0])
        else $error("set request did not select its id");

    a_drop_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_pending == 2'd1) && !r_last_add |-> !m_axis_tuser[1])
        else $error("drop flag on a non-add request");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen_valid |-> m_axis_tuser[0])
        else $error("selection lost its valid flag");

endmodule

bind directional_nearest_select dns_checker u_dns_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import dns_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int ITEMS       = 1400;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] id;
        logic [15:0]     x;
        logic [15:0]     y;
        logic [1:0]      dir;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] sel;
        logic            valid;
        logic            dropped;
    } t_sel;

    typedef struct {
        t_req req;
        bit   fixed;
        t_sel want;
    } t_vec;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // object_id[15:0], pos_x[31:16], pos_y[47:32], direction[49:48], zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // mode[1:0]
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // selection[15:0]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // selection_valid[0], add_dropped[1]
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // point table mirror
    logic [ID_W-1:0] tbl_id [MAX_POINTS];
    t_coord          tbl_x  [MAX_POINTS];
    t_coord          tbl_y  [MAX_POINTS];
    int              tbl_count;
    logic [ID_W-1:0] sel_id;
    logic            sel_ok;

    t_sel pending_sel[$];
    t_vec directed[$];
    t_sel got_sel;
    t_sel want_sel;
    int   errors;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   quiet_cycles;

    directional_nearest_select uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sel next_selection(t_req r);
        t_sel                     res;
        int                       cur;
        int                       best;
        bit                       found;
        bit                       have_best;
        bit                       in_dir;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0]        ax;
        logic [DIFF_W-1:0]        ay;
        logic [DIST_W-1:0]        d;
        logic [DIST_W-1:0]        best_d;
        res.dropped = 1'b0;
        case (r.mode)
            MODE_ADD: begin
                if (tbl_count >= MAX_POINTS) begin
                    res.dropped = 1'b1;
                end else begin
                    tbl_id[tbl_count] = r.id;
                    tbl_x[tbl_count]  = t_coord'($signed(r.x));
                    tbl_y[tbl_count]  = t_coord'($signed(r.y));
                    tbl_count++;
                    if (!sel_ok) begin
                        sel_id = r.id;
                        sel_ok = 1'b1;
                    end
                end
            end
            MODE_NAV: begin
                if (tbl_count != 0) begin
                    found = 0;
                    cur   = 0;
                    if (sel_ok) begin
                        for (int i = 0; i < tbl_count && !found; i++) begin
                            if (tbl_id[i] == sel_id) begin
                                cur   = i;
                                found = 1;
                            end
                        end
                    end
                    if (!found) begin
                        sel_id = tbl_id[0];
                        sel_ok = 1'b1;
                    end else begin
                        have_best = 0;
                        best      = 0;
                        best_d    = '0;
                        for (int i = 0; i < tbl_count; i++) begin
                            if (tbl_id[i] != tbl_id[cur]) begin
                                dx = DIFF_W'(tbl_x[i]) - DIFF_W'(tbl_x[cur]);
                                dy = DIFF_W'(tbl_y[i]) - DIFF_W'(tbl_y[cur]);
                                case (r.dir)
                                    DIR_UP:   in_dir = dy < 0;
                                    DIR_DOWN: in_dir = dy > 0;
                                    DIR_LEFT: in_dir = dx < 0;
                                    default:  in_dir = dx > 0;
                                endcase
                                if (in_dir) begin
                                    ax = (dx < 0) ? -dx : dx;
                                    ay = (dy < 0) ? -dy : dy;
                                    d  = DIST_W'(ax) * DIST_W'(ax) + DIST_W'(ay) * DIST_W'(ay);
                                    if (!have_best || d < best_d) begin
                                        have_best = 1;
                                        best_d    = d;
                                        best      = i;
                                    end
                                end
                            end
                        end
                        if (have_best) begin
                            sel_id = tbl_id[best];
                        end
                    end
                end
            end
            MODE_SET: begin
                sel_id = r.id;
                sel_ok = 1'b1;
            end
            default: ;
        endcase
        res.sel   = sel_id;
        res.valid = sel_ok;
        return res;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'(($urandom_range(0, 8) - 4) * 16);
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ID_W'($urandom_range(0, 40));
            6:                return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default:          return ID_W'($urandom);
        endcase
    endfunction

    // adds are likelier while the table fills than once it is full; navigates are always the most common kind
    function automatic t_req rand_request();
        t_req r;
        int   pick;
        pick  = $urandom_range(0, 99);
        r.id  = rand_id();
        r.x   = rand_coord();
        r.y   = rand_coord();
        r.dir = 2'($urandom);
        if (pick < ((tbl_count < MAX_POINTS) ? 25 : 8)) begin
            r.mode = MODE_ADD;
        end else if (pick < 75) begin
            r.mode = MODE_NAV;
        end else if (pick < 95) begin
            r.mode = MODE_SET;
            if (tbl_count != 0 && $urandom_range(0, 3) != 0)
                r.id = tbl_id[$urandom_range(0, tbl_count - 1)];
        end else begin
            r.mode = MODE_NOP;
        end
        return r;
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [15:0] id, logic [15:0] x,
                                    logic [15:0] y, logic [1:0] dir, bit fixed,
                                    logic [15:0] sel, logic valid, logic dropped);
        t_vec v;
        v.req  = '{mode: mode, id: id, x: x, y: y, dir: dir};
        v.fixed = fixed;
        v.want = '{sel: sel, valid: valid, dropped: dropped};
        directed.insert(directed.size(), v);
    endfunction

    // entered and left at a falling edge
    task automatic send_request(t_req r, bit fixed, t_sel want);
        t_sel pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r.dir, r.y, r.x, r.id};
        s_axis_tuser  <= r.mode;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = next_selection(r);
        pending_sel.insert(pending_sel.size(), fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_sel.size() != 0);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_sel = '{sel: m_axis_tdata, valid: m_axis_tuser[0], dropped: m_axis_tuser[1]};
            if (pending_sel.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %h", $time,
                         got_sel);
            end else begin
                want_sel = pending_sel.pop_front();
                if (got_sel.sel !== want_sel.sel) begin
                    errors++;
                    $display("%0t: selection expected %h actual %h", $time,
                             want_sel.sel, got_sel.sel);
                end
                if (got_sel.valid !== want_sel.valid) begin
                    errors++;
                    $display("%0t: selection_valid expected %b actual %b", $time,
                             want_sel.valid, got_sel.valid);
                end
                if (got_sel.dropped !== want_sel.dropped) begin
                    errors++;
                    $display("%0t: add_dropped expected %b actual %b", $time,
                             want_sel.dropped, got_sel.dropped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 36;
        snk_stall_pct = 55;
        quiet_cycles  = 0;
        errors        = 0;
        tbl_count     = 0;
        sel_id        = '0;
        sel_ok        = 1'b0;

        //      mode      id        x         y         dir     fix  sel     v  d
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_UP,    1, 16'h0000, 0, 0);
        add_row(MODE_NOP, 16'hffff, 16'hffff, 16'hffff, DIR_RIGHT, 1, 16'h0000, 0, 0);
        add_row(MODE_ADD, 16'h0010, 16'h0000, 16'h0000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'h0020, 16'h7fff, 16'h0000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'h0030, 16'h8000, 16'h0000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'h0040, 16'h0000, 16'h8000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'h0050, 16'h0000, 16'h7fff, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'hffff, 16'h8000, 16'h8000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_ADD, 16'h0000, 16'h0010, 16'h0010, DIR_UP,    1, 16'h0010, 1, 0);
        // equidistant right of the origin point: tie goes to the earlier entry
        add_row(MODE_ADD, 16'h0061, 16'h0010, 16'hfff0, DIR_UP,    1, 16'h0010, 1, 0);
        // duplicate of the current id, never a candidate
        add_row(MODE_ADD, 16'h0010, 16'h0064, 16'h0000, DIR_UP,    1, 16'h0010, 1, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_RIGHT, 0, 16'h0000, 0, 0);
        add_row(MODE_SET, 16'h0010, 16'h0000, 16'h0000, DIR_UP,    0, 16'h0000, 0, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_LEFT,  0, 16'h0000, 0, 0);
        add_row(MODE_SET, 16'h0010, 16'h0000, 16'h0000, DIR_UP,    0, 16'h0000, 0, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_UP,    0, 16'h0000, 0, 0);
        add_row(MODE_SET, 16'h0010, 16'h0000, 16'h0000, DIR_UP,    0, 16'h0000, 0, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_DOWN,  0, 16'h0000, 0, 0);
        // selection missing from the table falls back to the first entry
        add_row(MODE_SET, 16'hbeef, 16'h0000, 16'h0000, DIR_UP,    1, 16'hbeef, 1, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_LEFT,  1, 16'h0010, 1, 0);
        // nothing lies right of the largest X
        add_row(MODE_SET, 16'h0020, 16'h0000, 16'h0000, DIR_UP,    1, 16'h0020, 1, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_RIGHT, 1, 16'h0020, 1, 0);
        add_row(MODE_NOP, 16'h1234, 16'h5678, 16'h9abc, DIR_LEFT,  0, 16'h0000, 0, 0);
        add_row(MODE_SET, 16'hffff, 16'h0000, 16'h0000, DIR_UP,    0, 16'h0000, 0, 0);
        add_row(MODE_NAV, 16'h0000, 16'h0000, 16'h0000, DIR_RIGHT, 0, 16'h0000, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_request(directed[k].req, directed[k].fixed, directed[k].want);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 36;
                    snk_stall_pct = 55;
                end
                1: begin
                    src_idle_pct  = 55;
                    snk_stall_pct = 36;
                end
                default: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
            endcase
            drain_requests();
            repeat (ITEMS / 3) send_request(rand_request(), 1'b0, '0);
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending_sel.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
